### rtl/gdef_pkg.sv
package gdef_pkg;

    // defaults and fixed codes
    localparam int          PLAYER_COUNT_DEF = 2;
    localparam logic [6:0]  DEAD_ZONE_RESET  = 7'd16;
    localparam logic [6:0]  DEAD_ZONE_MAX    = 7'd126;
    localparam logic [6:0]  STICK_MAX        = 7'd127;
    localparam logic [7:0]  STICK_CENTER     = 8'd128;
    localparam logic [7:0]  KIND_ANALOG_A    = 8'h05;
    localparam logic [7:0]  KIND_ANALOG_B    = 8'h07;
    localparam int          AXIS_COUNT       = 4;
    localparam int          DIV_STEPS        = 7;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic shift;
        logic prep;
        logic load;
        logic div_step;
        logic store;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic analog_go;
        logic div_last;
        logic axis_last;
        logic out_free;
    } t_sts;

endpackage

### rtl/gdef_ctrl.sv
module gdef_ctrl
    import gdef_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PREP,
        S_LOAD,
        S_DIV,
        S_STORE,
        S_FIN
    } t_state;

    t_state r_state;

    assign o_ready = (r_state == S_IDLE);

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_valid;
        o_cmd.shift    = (r_state == S_SHIFT);
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.load     = (r_state == S_LOAD);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.store    = (r_state == S_STORE);
        o_cmd.out_load = (r_state == S_FIN) && i_sts.out_free;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_state <= i_sts.analog_go ? S_PREP : S_FIN;
                end
                S_PREP: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_last) r_state <= S_STORE;
                end
                S_STORE: begin
                    r_state <= i_sts.axis_last ? S_FIN : S_PREP;
                end
                S_FIN: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/gdef_dp.sv
module gdef_dp
    import gdef_pkg::*;
#(
    parameter int PLAYER_COUNT = PLAYER_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [6:0]        i_dead_zone,
    input  logic              i_player,
    input  logic [7:0]        i_link_status,
    input  logic [7:0]        i_pad_kind,
    input  logic [15:0]       i_raw_buttons,
    input  logic [7:0]        i_left_x_raw,
    input  logic [7:0]        i_left_y_raw,
    input  logic [7:0]        i_right_x_raw,
    input  logic [7:0]        i_right_y_raw,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_held_set,
    output logic [15:0]       o_pressed_set,
    output logic [15:0]       o_released_set,
    output logic signed [7:0] o_left_x,
    output logic signed [7:0] o_left_y,
    output logic signed [7:0] o_right_x,
    output logic signed [7:0] o_right_y,
    output logic signed [7:0] o_left_x_delta,
    output logic signed [7:0] o_left_y_delta,
    output logic signed [7:0] o_right_x_delta,
    output logic signed [7:0] o_right_y_delta
);

    localparam int PW = (PLAYER_COUNT > 1) ? $clog2(PLAYER_COUNT) : 1;

    // captured request
    logic        r_player;
    logic [7:0]  r_link;
    logic [7:0]  r_kind;
    logic [15:0] r_btn;
    logic [7:0]  r_raw [AXIS_COUNT];

    // per-player state
    logic [15:0] r_btn_now    [PLAYER_COUNT];
    logic [15:0] r_btn_before [PLAYER_COUNT];
    logic [7:0]  r_stk_now    [PLAYER_COUNT][AXIS_COUNT];
    logic [7:0]  r_stk_before [PLAYER_COUNT][AXIS_COUNT];

    // deadzone and divider registers
    logic [1:0]  r_axis;
    logic        r_neg;
    logic [6:0]  r_mag;
    logic [6:0]  r_rem;
    logic [6:0]  r_low;
    logic [6:0]  r_q;
    logic        r_sat;
    logic [2:0]  r_cnt;

    // output register
    logic        r_out_valid;
    logic [15:0] r_held, r_pressed, r_released;
    logic [7:0]  r_stk_out [AXIS_COUNT];
    logic [7:0]  r_dlt_out [AXIS_COUNT];

    logic          p_ok;
    logic [PW-1:0] pidx;
    logic          connected;
    logic          analog;
    logic [6:0]    span;
    logic [7:0]    raw_sel;
    logic          raw_neg;
    logic [7:0]    mag8;
    logic [7:0]    mag_sub;
    logic [6:0]    mag_clamp;
    logic [13:0]   num;
    logic [7:0]    trial;
    logic          trial_ge;
    logic [6:0]    q_fin;
    logic [7:0]    stk_val;

    assign p_ok      = (32'(r_player) < PLAYER_COUNT);
    assign pidx      = PW'(r_player);
    assign connected = (r_link == 8'd0);
    assign analog    = (r_kind == KIND_ANALOG_A) || (r_kind == KIND_ANALOG_B);
    assign span      = STICK_MAX - i_dead_zone;

    // magnitude around center, minus dead zone, clamped
    assign raw_sel   = r_raw[r_axis];
    assign raw_neg   = ~raw_sel[7];
    assign mag8      = raw_neg ? (STICK_CENTER - raw_sel) : (raw_sel - STICK_CENTER);
    assign mag_sub   = (mag8 > {1'b0, i_dead_zone}) ? (mag8 - {1'b0, i_dead_zone}) : 8'd0;
    assign mag_clamp = (mag_sub > {1'b0, STICK_MAX}) ? STICK_MAX : mag_sub[6:0];

    // mag * 127 as shift and subtract
    assign num       = {r_mag, 7'd0} - {7'd0, r_mag};

    // one restoring division step
    assign trial     = {r_rem, r_low[6]};
    assign trial_ge  = (trial >= {1'b0, span});

    // signed stick value from quotient
    assign q_fin     = r_sat ? STICK_MAX : r_q;
    assign stk_val   = r_neg ? (8'd0 - {1'b0, q_fin}) : {1'b0, q_fin};

    assign o_sts.analog_go = p_ok && connected && analog;
    assign o_sts.div_last  = (r_cnt == 3'(DIV_STEPS - 1));
    assign o_sts.axis_last = (r_axis == 2'(AXIS_COUNT - 1));
    assign o_sts.out_free  = !r_out_valid || i_ready;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_player <= i_player;
            r_link   <= i_link_status;
            r_kind   <= i_pad_kind;
            r_btn    <= i_raw_buttons;
            r_raw[0] <= i_left_x_raw;
            r_raw[1] <= i_left_y_raw;
            r_raw[2] <= i_right_x_raw;
            r_raw[3] <= i_right_y_raw;
        end
    end

    // player state: roll to previous, then update current
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLAYER_COUNT; p++) begin
                r_btn_now[p]    <= '0;
                r_btn_before[p] <= '0;
                for (int k = 0; k < AXIS_COUNT; k++) begin
                    r_stk_now[p][k]    <= '0;
                    r_stk_before[p][k] <= '0;
                end
            end
        end else begin
            if (i_cmd.shift && p_ok) begin
                r_btn_before[pidx] <= r_btn_now[pidx];
                for (int k = 0; k < AXIS_COUNT; k++) begin
                    r_stk_before[pidx][k] <= r_stk_now[pidx][k];
                end
                if (connected) r_btn_now[pidx] <= ~r_btn;
            end
            if (i_cmd.store) begin
                r_stk_now[pidx][r_axis] <= stk_val;
            end
        end
    end

    // axis walk and shared divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_axis <= '0;
        end else if (i_cmd.store) begin
            r_axis <= r_axis + 2'd1;
        end
        if (i_cmd.prep) begin
            r_neg <= raw_neg;
            r_mag <= mag_clamp;
        end
        if (i_cmd.load) begin
            r_sat <= (num >= {span, 7'd0});
            r_rem <= num[13:7];
            r_low <= num[6:0];
            r_q   <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? 7'(trial - {1'b0, span}) : trial[6:0];
            r_low <= {r_low[5:0], 1'b0};
            r_q   <= {r_q[5:0], trial_ge};
            r_cnt <= r_cnt + 3'd1;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, zero for a player out of range
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (p_ok) begin
                r_held     <= r_btn_now[pidx];
                r_pressed  <= r_btn_now[pidx] & ~r_btn_before[pidx];
                r_released <= r_btn_before[pidx] & ~r_btn_now[pidx];
                for (int k = 0; k < AXIS_COUNT; k++) begin
                    r_stk_out[k] <= r_stk_now[pidx][k];
                    r_dlt_out[k] <= r_stk_now[pidx][k] - r_stk_before[pidx][k];
                end
            end else begin
                r_held     <= '0;
                r_pressed  <= '0;
                r_released <= '0;
                for (int k = 0; k < AXIS_COUNT; k++) begin
                    r_stk_out[k] <= '0;
                    r_dlt_out[k] <= '0;
                end
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_held_set      = r_held;
    assign o_pressed_set   = r_pressed;
    assign o_released_set  = r_released;
    assign o_left_x        = r_stk_out[0];
    assign o_left_y        = r_stk_out[1];
    assign o_right_x       = r_stk_out[2];
    assign o_right_y       = r_stk_out[3];
    assign o_left_x_delta  = r_dlt_out[0];
    assign o_left_y_delta  = r_dlt_out[1];
    assign o_right_x_delta = r_dlt_out[2];
    assign o_right_y_delta = r_dlt_out[3];

endmodule

### rtl/gamepad_deadzone_edge_filter.sv
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+------------------------------------------
// poll     | in        | i_valid / o_ready        | player, link, kind, buttons, 4 raw sticks
// result   | out       | o_valid / i_ready        | held/pressed/released sets, sticks, deltas
// config   | in        | i_cfg_valid / o_cfg_ready| dead_zone (7 bits)
//
// a poll is accepted only in idle and runs to the end before the next is taken; for an
// analog poll from a connected pad one shared restoring divider runs 7 steps per axis over
// the four axes, any other poll goes from shift straight to fin; the result sits in an
// output register, so a stalled result only holds the block when the following poll finishes
// synchronous active-low reset clears player state, dead_zone goes to 16
module gamepad_deadzone_edge_filter
    import gdef_pkg::*;
#(
    parameter int PLAYER_COUNT = PLAYER_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_player,
    input  logic [7:0]        i_link_status,
    input  logic [7:0]        i_pad_kind,
    input  logic [15:0]       i_raw_buttons,
    input  logic [7:0]        i_left_x_raw,
    input  logic [7:0]        i_left_y_raw,
    input  logic [7:0]        i_right_x_raw,
    input  logic [7:0]        i_right_y_raw,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_held_set,
    output logic [15:0]       o_pressed_set,
    output logic [15:0]       o_released_set,
    output logic signed [7:0] o_left_x,
    output logic signed [7:0] o_left_y,
    output logic signed [7:0] o_right_x,
    output logic signed [7:0] o_right_y,
    output logic signed [7:0] o_left_x_delta,
    output logic signed [7:0] o_left_y_delta,
    output logic signed [7:0] o_right_x_delta,
    output logic signed [7:0] o_right_y_delta,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [6:0]        i_cfg_dead_zone
);

    logic [6:0] r_dead_zone;
    t_cmd       cmd;
    t_sts       sts;

    assign o_cfg_ready = 1'b1;

    // dead zone register, top code saturates to the largest legal value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= DEAD_ZONE_RESET;
        end else if (i_cfg_valid) begin
            r_dead_zone <= (i_cfg_dead_zone > DEAD_ZONE_MAX) ? DEAD_ZONE_MAX : i_cfg_dead_zone;
        end
    end

    // sequencer
    gdef_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // state, deadzone divider and result register
    gdef_dp #(
        .PLAYER_COUNT (PLAYER_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_dead_zone     (r_dead_zone),
        .i_player        (i_player),
        .i_link_status   (i_link_status),
        .i_pad_kind      (i_pad_kind),
        .i_raw_buttons   (i_raw_buttons),
        .i_left_x_raw    (i_left_x_raw),
        .i_left_y_raw    (i_left_y_raw),
        .i_right_x_raw   (i_right_x_raw),
        .i_right_y_raw   (i_right_y_raw),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_held_set      (o_held_set),
        .o_pressed_set   (o_pressed_set),
        .o_released_set  (o_released_set),
        .o_left_x        (o_left_x),
        .o_left_y        (o_left_y),
        .o_right_x       (o_right_x),
        .o_right_y       (o_right_y),
        .o_left_x_delta  (o_left_x_delta),
        .o_left_y_delta  (o_left_y_delta),
        .o_right_x_delta (o_right_x_delta),
        .o_right_y_delta (o_right_y_delta)
    );

endmodule

### verif/gamepad_deadzone_edge_filter_test.sv
module gamepad_deadzone_edge_filter_test
    import gdef_pkg::*;
();

    localparam int PLAYERS         = PLAYER_COUNT_DEF;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_POLLS     = 100;
    localparam int DRAIN_CYCLES    = 50;

    // one controller poll as offered on the request channel
    typedef struct packed {
        logic            player;
        logic [7:0]      link;
        logic [7:0]      kind;
        logic [15:0]     buttons;
        logic [3:0][7:0] stick;
    } t_poll;

    // one filtered frame as seen on the result channel
    typedef struct packed {
        logic [15:0]     held;
        logic [15:0]     pressed;
        logic [15:0]     released;
        logic [3:0][7:0] stick;
        logic [3:0][7:0] delta;
    } t_frame;

    // per-player pad state and the frames it predicts
    class deadzone_scoreboard;
        logic [6:0]  dead_zone;
        logic [15:0] buttons_now [PLAYERS];
        logic [15:0] buttons_before [PLAYERS];
        logic [7:0]  sticks_now [PLAYERS][4];
        logic [7:0]  sticks_before [PLAYERS][4];
        t_frame      frame_q[$];
        string       axis_name[4] = '{"left_x", "left_y", "right_x", "right_y"};
        int          mismatches;
        int          frames_checked;
        int          polls_seen;
        int          analog_polls;
        int          frozen_polls;

        function new();
            dead_zone = DEAD_ZONE_RESET;
            foreach (buttons_now[p]) begin
                buttons_now[p]    = '0;
                buttons_before[p] = '0;
                for (int k = 0; k < 4; k++) begin
                    sticks_now[p][k]    = '0;
                    sticks_before[p][k] = '0;
                end
            end
        endfunction

        // a write above the top of the range lands on the top
        function void set_dead_zone(logic [6:0] value);
            dead_zone = (value > DEAD_ZONE_MAX) ? DEAD_ZONE_MAX : value;
        endfunction

        // sign-magnitude dead zone, then rescale to full range
        function logic [7:0] shape_stick(logic [7:0] raw);
            int  mag;
            int  span;
            bit  neg;
            neg  = raw < STICK_CENTER;
            mag  = neg ? int'(STICK_CENTER) - int'(raw) : int'(raw) - int'(STICK_CENTER);
            mag  = (mag > int'(dead_zone)) ? mag - int'(dead_zone) : 0;
            if (mag > int'(STICK_MAX))
                mag = int'(STICK_MAX);
            span = int'(STICK_MAX) - int'(dead_zone);
            mag  = (mag * int'(STICK_MAX)) / span;
            if (mag > int'(STICK_MAX))
                mag = int'(STICK_MAX);
            return neg ? 8'(256 - mag) : 8'(mag);
        endfunction

        function void note_poll(t_poll poll);
            t_frame f;
            int     p;
            p = int'(poll.player);
            polls_seen++;
            buttons_before[p] = buttons_now[p];
            for (int k = 0; k < 4; k++)
                sticks_before[p][k] = sticks_now[p][k];
            if (poll.link == 8'd0) begin
                buttons_now[p] = ~poll.buttons;
                if (poll.kind == KIND_ANALOG_A || poll.kind == KIND_ANALOG_B) begin
                    analog_polls++;
                    for (int k = 0; k < 4; k++)
                        sticks_now[p][k] = shape_stick(poll.stick[k]);
                end
            end else begin
                frozen_polls++;
            end
            f.held     = buttons_now[p];
            f.pressed  = buttons_now[p] & ~buttons_before[p];
            f.released = buttons_before[p] & ~buttons_now[p];
            for (int k = 0; k < 4; k++) begin
                f.stick[k] = sticks_now[p][k];
                f.delta[k] = sticks_now[p][k] - sticks_before[p][k];
            end
            frame_q.push_back(f);
        endfunction

        function void report(string what, logic [15:0] want_v, logic [15:0] got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in frame %0d, %s: expected %h, got %h",
                         frames_checked, what, want_v, got_v);
        endfunction

        function void check_result(t_frame got);
            t_frame want;
            if (frame_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("frame with no request behind it: held %h", got.held);
                return;
            end
            want = frame_q.pop_front();
            frames_checked++;
            if (got.held !== want.held)
                report("held_set", want.held, got.held);
            if (got.pressed !== want.pressed)
                report("pressed_set", want.pressed, got.pressed);
            if (got.released !== want.released)
                report("released_set", want.released, got.released);
            for (int k = 0; k < 4; k++) begin
                if (got.stick[k] !== want.stick[k])
                    report(axis_name[k], 16'(want.stick[k]), 16'(got.stick[k]));
                if (got.delta[k] !== want.delta[k])
                    report({axis_name[k], "_delta"}, 16'(want.delta[k]),
                           16'(got.delta[k]));
            end
        endfunction

        function int pending();
            return frame_q.size();
        endfunction

        function void flag_leftovers();
            if (frame_q.size() != 0) begin
                mismatches += frame_q.size();
                $display("%0d expected frames never came out", frame_q.size());
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_player;
    logic [7:0]        i_link_status;
    logic [7:0]        i_pad_kind;
    logic [15:0]       i_raw_buttons;
    logic [7:0]        i_left_x_raw;
    logic [7:0]        i_left_y_raw;
    logic [7:0]        i_right_x_raw;
    logic [7:0]        i_right_y_raw;
    logic              o_valid;
    logic              i_ready;
    logic [15:0]       o_held_set;
    logic [15:0]       o_pressed_set;
    logic [15:0]       o_released_set;
    logic signed [7:0] o_left_x;
    logic signed [7:0] o_left_y;
    logic signed [7:0] o_right_x;
    logic signed [7:0] o_right_y;
    logic signed [7:0] o_left_x_delta;
    logic signed [7:0] o_left_y_delta;
    logic signed [7:0] o_right_x_delta;
    logic signed [7:0] o_right_y_delta;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [6:0]        i_cfg_dead_zone;

    deadzone_scoreboard sb = new();
    int                 cycle_count = 0;
    bit                 steady_flow = 1'b0;
    bit                 hold_off_req = 1'b0;
    int                 settings_used = 0;

    gamepad_deadzone_edge_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_player        (i_player),
        .i_link_status   (i_link_status),
        .i_pad_kind      (i_pad_kind),
        .i_raw_buttons   (i_raw_buttons),
        .i_left_x_raw    (i_left_x_raw),
        .i_left_y_raw    (i_left_y_raw),
        .i_right_x_raw   (i_right_x_raw),
        .i_right_y_raw   (i_right_y_raw),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_held_set      (o_held_set),
        .o_pressed_set   (o_pressed_set),
        .o_released_set  (o_released_set),
        .o_left_x        (o_left_x),
        .o_left_y        (o_left_y),
        .o_right_x       (o_right_x),
        .o_right_y       (o_right_y),
        .o_left_x_delta  (o_left_x_delta),
        .o_left_y_delta  (o_left_y_delta),
        .o_right_x_delta (o_right_x_delta),
        .o_right_y_delta (o_right_y_delta),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_dead_zone (i_cfg_dead_zone)
    );

    always #4 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d frames still due",
                     cycle_count, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // accepted polls feed the predictor
    always @(posedge i_clk) begin
        t_poll seen;
        if (i_rst_n && i_valid && o_ready) begin
            seen.player  = i_player;
            seen.link    = i_link_status;
            seen.kind    = i_pad_kind;
            seen.buttons = i_raw_buttons;
            seen.stick   = {i_right_y_raw, i_right_x_raw, i_left_y_raw, i_left_x_raw};
            sb.note_poll(seen);
        end
    end

    // accepted frames are checked against the oldest prediction
    always @(posedge i_clk) begin
        t_frame got;
        if (i_rst_n && o_valid && i_ready) begin
            got.held     = o_held_set;
            got.pressed  = o_pressed_set;
            got.released = o_released_set;
            got.stick    = {o_right_y, o_right_x, o_left_y, o_left_x};
            got.delta    = {o_right_y_delta, o_right_x_delta, o_left_y_delta, o_left_x_delta};
            sb.check_result(got);
        end
    end

    // mostly short idle stretches, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, or one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic t_poll mk_poll(logic player, logic [7:0] link, logic [7:0] kind,
                                      logic [15:0] buttons, logic [7:0] lx, logic [7:0] ly,
                                      logic [7:0] rx, logic [7:0] ry);
        t_poll p;
        p.player  = player;
        p.link    = link;
        p.kind    = kind;
        p.buttons = buttons;
        p.stick   = {ry, rx, ly, lx};
        return p;
    endfunction

    // stick byte: anywhere, near center, at the rails or on the dead-zone edge
    function automatic logic [7:0] pick_stick(int dz);
        int off;
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 255);
            4, 5, 6: begin
                off = $urandom_range(0, dz + 4);
                v   = $urandom_range(0, 1) ? 128 + off : 128 - off;
            end
            7: begin
                case ($urandom_range(0, 6))
                    0: v = 0;
                    1: v = 1;
                    2: v = 127;
                    3: v = 128;
                    4: v = 129;
                    5: v = 254;
                    default: v = 255;
                endcase
            end
            default: begin
                off = dz + $urandom_range(0, 2);
                v   = $urandom_range(0, 1) ? 128 + off - 1 : 128 - off + 1;
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    function automatic t_poll random_poll(int dz);
        t_poll p;
        int    r;
        p.player = 1'($urandom_range(0, 1));
        p.link   = ($urandom_range(0, 9) < 8) ? 8'd0 : 8'($urandom_range(1, 255));
        r = $urandom_range(0, 9);
        if (r < 7)
            p.kind = $urandom_range(0, 1) ? KIND_ANALOG_A : KIND_ANALOG_B;
        else
            p.kind = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 19);
        if (r < 14)
            p.buttons = 16'($urandom_range(0, 65535));
        else if (r < 17)
            p.buttons = 16'hFFFF;
        else
            p.buttons = ~(16'd1 << $urandom_range(0, 15));
        for (int k = 0; k < 4; k++)
            p.stick[k] = pick_stick(dz);
        return p;
    endfunction

    // raise the request and hold it until accepted
    task automatic send_poll(t_poll p);
        i_valid       <= 1'b1;
        i_player      <= p.player;
        i_link_status <= p.link;
        i_pad_kind    <= p.kind;
        i_raw_buttons <= p.buttons;
        i_left_x_raw  <= p.stick[0];
        i_left_y_raw  <= p.stick[1];
        i_right_x_raw <= p.stick[2];
        i_right_y_raw <= p.stick[3];
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    task automatic idle_sender();
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_dead_zone(logic [6:0] value);
        pause_until_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_dead_zone <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_dead_zone(value);
        settings_used++;
    endtask

    initial begin
        t_poll      directed[$];
        logic [6:0] settings[8];

        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_player        <= 1'b0;
        i_link_status   <= '0;
        i_pad_kind      <= '0;
        i_raw_buttons   <= '0;
        i_left_x_raw    <= '0;
        i_left_y_raw    <= '0;
        i_right_x_raw   <= '0;
        i_right_y_raw   <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_dead_zone <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed polls at the reset dead zone
        directed.push_back(mk_poll(0, 8'h00, KIND_ANALOG_A, 16'hFFFF, 128, 128, 128, 128));
        directed.push_back(mk_poll(0, 8'h00, KIND_ANALOG_B, 16'h0000, 0, 255, 0, 255));
        directed.push_back(mk_poll(0, 8'h00, KIND_ANALOG_A, 16'hA5A5, 112, 144, 111, 145));
        directed.push_back(mk_poll(1, 8'h00, KIND_ANALOG_B, 16'h5A5A, 1, 254, 64, 192));
        directed.push_back(mk_poll(1, 8'hFF, KIND_ANALOG_A, 16'h0000, 0, 0, 0, 0));
        directed.push_back(mk_poll(1, 8'h01, KIND_ANALOG_B, 16'hFFFF, 255, 255, 255, 255));
        directed.push_back(mk_poll(1, 8'h00, KIND_ANALOG_A, 16'hFFFE, 255, 0, 255, 0));
        directed.push_back(mk_poll(0, 8'h00, 8'h04, 16'h0F0F, 0, 0, 0, 0));
        directed.push_back(mk_poll(0, 8'h00, 8'h06, 16'hF0F0, 255, 255, 255, 255));
        directed.push_back(mk_poll(0, 8'h00, 8'h00, 16'hFFFF, 10, 20, 30, 40));
        directed.push_back(mk_poll(0, 8'h00, 8'hFF, 16'h0000, 200, 100, 50, 250));
        directed.push_back(mk_poll(0, 8'h00, 8'h85, 16'h1234, 0, 255, 0, 255));
        directed.push_back(mk_poll(0, 8'h00, 8'h87, 16'hEDCB, 1, 2, 3, 4));
        directed.push_back(mk_poll(0, 8'h80, KIND_ANALOG_A, 16'h0000, 0, 0, 0, 0));
        directed.push_back(mk_poll(0, 8'h00, KIND_ANALOG_A, 16'hFFFF, 127, 129, 126, 130));
        directed.push_back(mk_poll(1, 8'h00, KIND_ANALOG_B, 16'h7FFF, 128, 0, 255, 128));
        directed.push_back(mk_poll(0, 8'h00, KIND_ANALOG_B, 16'hFFFF, 128, 128, 128, 128));
        steady_flow = 1'b1;
        foreach (directed[i])
            send_poll(directed[i]);
        steady_flow = 1'b0;

        // result side held off while random polls keep coming
        hold_off_req = 1'b1;
        for (int i = 0; i < 10; i++)
            send_poll(random_poll(int'(sb.dead_zone)));
        pause_until_drained();

        // random phases over several dead-zone settings
        settings = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd126, 7'($urandom_range(0, 127)),
                     DEAD_ZONE_RESET, 7'($urandom_range(0, 127))};
        foreach (settings[s]) begin
            write_dead_zone(settings[s]);
            steady_flow = 1'b1;
            for (int i = 0; i < PHASE_POLLS; i++) begin
                if (i == 20)
                    steady_flow = 1'b0;
                send_poll(random_poll(int'(sb.dead_zone)));
                if ($urandom_range(0, 49) == 0)
                    pause_until_drained();
                else
                    idle_sender();
            end
            steady_flow = 1'b0;
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();

        $display("covered %0d polls (%0d analog, %0d from unplugged pads) over %0d dead zones",
                 sb.polls_seen, sb.analog_polls, sb.frozen_polls, settings_used + 1);
        $display("checked %0d frames, %0d mismatches", sb.frames_checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### gamepad_deadzone_edge_filter.f
rtl/gdef_pkg.sv
rtl/gdef_ctrl.sv
rtl/gdef_dp.sv
rtl/gamepad_deadzone_edge_filter.sv
verif/gamepad_deadzone_edge_filter_test.sv
